>>> design/rsg_pkg.sv
// Shared constants and types for the radial smear grid unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rsg_pkg;

    // Default parameter values
    localparam int GRID_SIDE_DEF    = 64;
    localparam int STEPS_DEF        = 10;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths of the ports
    localparam int POS_W       = 6;
    localparam int PORT_SMPL_W = 16;

    // Fixed point: scale table Q2.22, coordinates in units of 2^-23
    localparam int SCALE_FRAC = 22;
    localparam int COORD_FRAC = 23;
    localparam int SCALE_W    = 24;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Control that travels with one tap down the gather pipeline
    typedef struct packed {
        logic valid;
        logic in_grid;
        logic last;
    } tap_ctrl_t;

endpackage

`default_nettype wire

>>> design/rsg_tap_gen.sv
// Tap coordinate generator: scale table, one tap per cycle, two stages.
// Depends on rsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsg_tap_gen
    import rsg_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int STEPS     = STEPS_DEF,
    localparam int COORD_W  = $clog2(GRID_SIDE)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [POS_W-1:0]   pos_x,
    input  wire logic [POS_W-1:0]   pos_y,
    output logic      [COORD_W-1:0] tap_x,
    output logic      [COORD_W-1:0] tap_y,
    output tap_ctrl_t               tap_ctrl
);

    localparam int  TAPS  = 2 * STEPS + 1;
    localparam int  TAP_W = $clog2(TAPS);
    localparam int  HO_W  = (COORD_W + 2 > POS_W + 2) ? COORD_W + 2 : POS_W + 2;
    localparam int  PR_W  = HO_W + SCALE_W;
    localparam int  T_W   = PR_W + 1;
    localparam longint DEN     = 200 * TAPS;
    localparam longint ONE_Q   = longint'(1) << SCALE_FRAC;
    localparam longint C_FIX_L = longint'(GRID_SIDE / 2) << COORD_FRAC;
    localparam longint NEG_L   = -(longint'(1) << COORD_FRAC);
    localparam logic signed [T_W-1:0] C_FIX   = T_W'(C_FIX_L);
    localparam logic signed [T_W-1:0] NEG_LIM = T_W'(NEG_L);

    // Scale table, built at elaboration
    logic signed [SCALE_W-1:0] scale_tab [TAPS];

    for (genvar g = 0; g < TAPS; g++) begin : g_scale
        localparam int     K   = g - STEPS;
        localparam longint MAG = longint'((K < 0) ? -K : K) * ONE_Q;
        localparam longint Q   = (MAG + DEN / 2) / DEN;
        assign scale_tab[g] = SCALE_W'((K < 0) ? ONE_Q - Q : ONE_Q + Q);
    end

    logic                   run_reg, run_next;
    logic [TAP_W-1:0]       cnt_reg, cnt_next;
    logic signed [HO_W-1:0] ho_x_reg, ho_x_next;
    logic signed [HO_W-1:0] ho_y_reg, ho_y_next;

    logic signed [PR_W-1:0] prod_x_reg, prod_y_reg;
    tap_ctrl_t              ctrl1_reg, ctrl1_next;

    logic [COORD_W-1:0] tap_x_reg, tap_y_reg;
    tap_ctrl_t          ctrl2_reg, ctrl2_next;

    logic signed [T_W-1:0]  t_x, t_y, ix_full, iy_full;
    logic [COORD_W-1:0]     ix, iy;
    logic                   ok_x, ok_y;

    // Half-unit offset 2*(p-c)+1
    function automatic logic signed [HO_W-1:0] half_off(input logic [POS_W-1:0] p);
        logic signed [HO_W-1:0] two_p;
        two_p = signed'(HO_W'({p, 1'b1}));
        return two_p - HO_W'(GRID_SIDE);
    endfunction

    // Sequencer
    always_comb begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        ho_x_next = ho_x_reg;
        ho_y_next = ho_y_reg;
        if (start) begin
            run_next  = 1'b1;
            cnt_next  = '0;
            ho_x_next = half_off(pos_x);
            ho_y_next = half_off(pos_y);
        end else if (run_reg) begin
            if (cnt_reg == TAP_W'(TAPS - 1)) begin
                run_next = 1'b0;
            end
            cnt_next = cnt_reg + 1'b1;
        end
        ctrl1_next.valid   = run_reg;
        ctrl1_next.in_grid = 1'b0;
        ctrl1_next.last    = (cnt_reg == TAP_W'(TAPS - 1));
    end

    // Stage 2: offset to integer coordinate, truncated toward zero
    always_comb begin
        t_x     = C_FIX + T_W'(prod_x_reg);
        t_y     = C_FIX + T_W'(prod_y_reg);
        ix_full = t_x >>> COORD_FRAC;
        iy_full = t_y >>> COORD_FRAC;
        ok_x    = t_x[T_W-1] ? (t_x > NEG_LIM) : (ix_full < GRID_SIDE);
        ok_y    = t_y[T_W-1] ? (t_y > NEG_LIM) : (iy_full < GRID_SIDE);
        ix      = t_x[T_W-1] ? '0 : COORD_W'(ix_full);
        iy      = t_y[T_W-1] ? '0 : COORD_W'(iy_full);
        ctrl2_next.valid   = ctrl1_reg.valid;
        ctrl2_next.in_grid = ok_x & ok_y;
        ctrl2_next.last    = ctrl1_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            cnt_reg   <= '0;
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end else begin
            run_reg   <= run_next;
            cnt_reg   <= cnt_next;
            ctrl1_reg <= ctrl1_next;
            ctrl2_reg <= ctrl2_next;
        end
        ho_x_reg   <= ho_x_next;
        ho_y_reg   <= ho_y_next;
        prod_x_reg <= ho_x_reg * scale_tab[cnt_reg];
        prod_y_reg <= ho_y_reg * scale_tab[cnt_reg];
        tap_x_reg  <= ix;
        tap_y_reg  <= iy;
    end

    assign tap_x    = tap_x_reg;
    assign tap_y    = tap_y_reg;
    assign tap_ctrl = ctrl2_reg;

endmodule

`default_nettype wire

>>> design/rsg_grid_mem.sv
// Sample grid memory: one write port, one registered read port.
// Depends on rsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsg_grid_mem
    import rsg_pkg::*;
#(
    parameter int GRID_SIDE    = GRID_SIDE_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int COORD_W     = $clog2(GRID_SIDE),
    localparam int DATA_W      = 2 * SAMPLE_WIDTH
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [COORD_W-1:0] wr_x,
    input  wire logic [COORD_W-1:0] wr_y,
    input  wire logic [DATA_W-1:0]  wr_data,
    input  wire logic [COORD_W-1:0] rd_x,
    input  wire logic [COORD_W-1:0] rd_y,
    output logic      [DATA_W-1:0]  rd_data
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    assign wr_addr = ADDR_W'(wr_y) * ADDR_W'(GRID_SIDE) + ADDR_W'(wr_x);
    assign rd_addr = ADDR_W'(rd_y) * ADDR_W'(GRID_SIDE) + ADDR_W'(rd_x);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/rsg_avg_div.sv
// Divide by the tap count, two lanes, by reciprocal multiplication.
// Depends on rsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsg_avg_div
    import rsg_pkg::*;
#(
    parameter int STEPS        = STEPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int TAPS        = 2 * STEPS + 1,
    localparam int ACC_W       = SAMPLE_WIDTH + $clog2(TAPS) + 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic signed [ACC_W-1:0]        num_re,
    input  wire logic signed [ACC_W-1:0]        num_im,
    input  wire logic                           ack,
    output logic                                res_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      quot_re,
    output logic signed [SAMPLE_WIDTH-1:0]      quot_im
);

    // floor(m * RCP / 2^SHIFT) == floor(m / TAPS) for every m below 2^ACC_W
    localparam int     SHIFT  = ACC_W + $clog2(TAPS);
    localparam int     PROD_W = 2 * ACC_W + 1;
    localparam longint RCP_L  = ((longint'(1) << SHIFT) + longint'(TAPS) - 1)
                                / longint'(TAPS);
    localparam logic [ACC_W:0] RCP = (ACC_W + 1)'(RCP_L);

    logic                    mul_reg, mul_next;
    logic                    done_reg, done_next;
    logic [ACC_W-1:0]        mag_reg  [2];
    logic [ACC_W-1:0]        mag_next [2];
    logic                    neg_reg  [2];
    logic [ACC_W-1:0]        q_reg    [2];
    logic [ACC_W-1:0]        q_next   [2];
    logic signed [ACC_W-1:0] num      [2];
    logic [PROD_W-1:0]       prod     [2];
    logic [ACC_W-1:0]        res      [2];

    assign num[0] = num_re;
    assign num[1] = num_im;

    always_comb begin
        mul_next  = start;
        done_next = done_reg;
        if (ack) begin
            done_next = 1'b0;
        end
        if (mul_reg) begin
            done_next = 1'b1;
        end
        // sign and magnitude in, truncation toward zero on the way out
        for (int l = 0; l < 2; l++) begin
            mag_next[l] = num[l][ACC_W-1] ? ACC_W'(-num[l]) : ACC_W'(num[l]);
            prod[l]     = PROD_W'(mag_reg[l]) * PROD_W'(RCP);
            q_next[l]   = ACC_W'(prod[l][PROD_W-1:SHIFT]);
            res[l]      = neg_reg[l] ? ACC_W'(-q_reg[l]) : q_reg[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= mul_next;
            done_reg <= done_next;
        end
        for (int l = 0; l < 2; l++) begin
            if (start) begin
                mag_reg[l] <= mag_next[l];
                neg_reg[l] <= num[l][ACC_W-1];
            end
            if (mul_reg) begin
                q_reg[l] <= q_next[l];
            end
        end
    end

    assign res_valid = done_reg;
    assign quot_re   = SAMPLE_WIDTH'(res[0]);
    assign quot_im   = SAMPLE_WIDTH'(res[1]);

endmodule

`default_nettype wire

>>> design/radial_smear_grid_unit.sv
// Flow: a write is stored at its transfer edge; a read raises m_valid once
//   its taps have passed 3 pipeline stages, one grid memory read per tap,
//   the divide's magnitude and quotient registers and the output register.
// Throughput: one write per cycle while idle; a read holds off new items
//   until its result can enter the output register.
// Reset: aresetn synchronous, active low; clears control, grid left undefined.
`timescale 1ns / 1ps
`default_nettype none

module radial_smear_grid_unit
    import rsg_pkg::*;
#(
    parameter int GRID_SIDE    = GRID_SIDE_DEF,
    parameter int STEPS        = STEPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic [POS_W-1:0]              s_pos_x,
    input  wire logic [POS_W-1:0]              s_pos_y,
    input  wire logic signed [PORT_SMPL_W-1:0] s_sample_re,
    input  wire logic signed [PORT_SMPL_W-1:0] s_sample_im,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [PORT_SMPL_W-1:0]      m_smeared_re,
    output logic signed [PORT_SMPL_W-1:0]      m_smeared_im
);

    localparam int TAPS    = 2 * STEPS + 1;
    localparam int ACC_W   = SAMPLE_WIDTH + $clog2(TAPS) + 1;
    localparam int COORD_W = $clog2(GRID_SIDE);
    localparam int OUT_W   = (SAMPLE_WIDTH < PORT_SMPL_W) ? SAMPLE_WIDTH : PORT_SMPL_W;
    localparam int SW      = SAMPLE_WIDTH;

    // Controller states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GATHER = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;

    logic [1:0] state_reg, state_next;

    logic s_xfer, m_xfer, rd_start, wr_en;

    // Tap pipeline signals
    logic [COORD_W-1:0] tap_x, tap_y;
    tap_ctrl_t          tap_ctrl;
    tap_ctrl_t          ctrl3_reg;

    logic [2*SW-1:0]    wr_data, rd_data;
    logic signed [PORT_SMPL_W-1:0] raw_re, raw_im;

    // Accumulators, sized to hold TAPS full-scale samples
    logic signed [ACC_W-1:0] acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0] acc_im_reg, acc_im_next;

    logic                 div_start, div_ack, div_valid;
    logic signed [SW-1:0] quot_re, quot_im;

    // Output register: lets the next item in while a result waits
    logic                          m_valid_reg, m_valid_next;
    logic [PORT_SMPL_W-1:0]        m_re_reg, m_im_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid & s_ready;
    assign m_xfer  = m_valid_reg & m_ready;

    assign rd_start = s_xfer & (s_func == FUNC_READ);
    // writes beyond the grid are dropped
    assign wr_en    = s_xfer & (s_func == FUNC_WRITE)
                      & (int'(s_pos_x) < GRID_SIDE) & (int'(s_pos_y) < GRID_SIDE);

    // sample fields taken at their low SAMPLE_WIDTH bits
    assign raw_re  = s_sample_re;
    assign raw_im  = s_sample_im;
    assign wr_data = {SW'(raw_im), SW'(raw_re)};

    rsg_tap_gen #(
        .GRID_SIDE (GRID_SIDE),
        .STEPS     (STEPS)
    ) u_tap_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rd_start),
        .pos_x    (s_pos_x),
        .pos_y    (s_pos_y),
        .tap_x    (tap_x),
        .tap_y    (tap_y),
        .tap_ctrl (tap_ctrl)
    );

    rsg_grid_mem #(
        .GRID_SIDE    (GRID_SIDE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_grid_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_x    (COORD_W'(s_pos_x)),
        .wr_y    (COORD_W'(s_pos_y)),
        .wr_data (wr_data),
        .rd_x    (tap_x),
        .rd_y    (tap_y),
        .rd_data (rd_data)
    );

    // Accumulate taps as read data returns; out-of-grid taps add nothing
    always_comb begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (rd_start) begin
            acc_re_next = '0;
            acc_im_next = '0;
        end else if (ctrl3_reg.valid && ctrl3_reg.in_grid) begin
            acc_re_next = acc_re_reg + ACC_W'(signed'(rd_data[SW-1:0]));
            acc_im_next = acc_im_reg + ACC_W'(signed'(rd_data[2*SW-1:SW]));
        end
    end

    assign div_start = (state_reg == ST_GATHER) & ctrl3_reg.valid & ctrl3_reg.last;
    assign div_ack   = (state_reg == ST_DIVIDE) & div_valid & (~m_valid_reg | m_ready);

    rsg_avg_div #(
        .STEPS        (STEPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_avg_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .num_re    (acc_re_next),
        .num_im    (acc_im_next),
        .ack       (div_ack),
        .res_valid (div_valid),
        .quot_re   (quot_re),
        .quot_im   (quot_im)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (rd_start) begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: begin
                if (div_start) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_xfer) begin
            m_valid_next = 1'b0;
        end
        if (div_ack) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ctrl3_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ctrl3_reg   <= tap_ctrl;
            m_valid_reg <= m_valid_next;
        end
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        if (div_ack) begin
            // results masked to the narrower of SAMPLE_WIDTH and PORT_SMPL_W bits
            m_re_reg <= PORT_SMPL_W'(quot_re[OUT_W-1:0]);
            m_im_reg <= PORT_SMPL_W'(quot_im[OUT_W-1:0]);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_smeared_re = m_re_reg;
    assign m_smeared_im = m_im_reg;

endmodule

`default_nettype wire

>>> design/rsg_checker.sv
// Port-level checks for radial_smear_grid_unit, bound to the top level.
// Depends on rsg_pkg and radial_smear_grid_unit.
`timescale 1ns / 1ps
`default_nettype none

module rsg_checker
    import rsg_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   s_func,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [PORT_SMPL_W-1:0] m_smeared_re,
    input wire logic [PORT_SMPL_W-1:0] m_smeared_im
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a waiting result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_smeared_re) && $stable(m_smeared_im))
        else $error("stalled result changed");

    // a write leaves the block ready for the next transfer
    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_WRITE |=> s_ready)
        else $error("not ready after write");

    // a read occupies the block while it gathers
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_READ |=> !s_ready)
        else $error("ready right after read");

endmodule

bind radial_smear_grid_unit rsg_checker u_rsg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_func       (s_func),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_smeared_re (m_smeared_re),
    .m_smeared_im (m_smeared_im)
);

`default_nettype wire
